/* sv/rdsm_pkg.sv */
`timescale 1ns / 1ps
package rdsm_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int WORD_W    = 64;
    localparam int LENGTH_W  = 6;
    localparam int REG_IDX_W = 3;

    localparam logic [7:0] STAR_CODE = 8'h2A;
    localparam logic [7:0] DOT_CODE  = 8'h2E;

    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_SECOND = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_THIRD  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;

    // what a queued request does to the row
    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_LAST,
        KIND_EMPTY
    } rdsm_kind_t;

endpackage

/* sv/rdsm_cfg.sv */
`timescale 1ns / 1ps
module rdsm_cfg #(
    parameter int MAX_PATTERN = rdsm_pkg::MAX_PATTERN_DEF,
    parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [rdsm_pkg::REG_IDX_W-1:0]     cfg_wr_index,
    input  logic [rdsm_pkg::WORD_W-1:0]        cfg_wr_data,
    output logic [MAX_PATTERN*8-1:0]           pattern_bytes,
    output logic [MAX_PATTERN-1:0]             star_mask,
    output logic [MAX_PATTERN-1:0]             use_mask,
    output logic [LEN_W-1:0]                   used_len,
    output logic [MAX_PATTERN:0]               start_row
);
    import rdsm_pkg::*;

    logic [WORD_W-1:0]   words_reg [4];
    logic [LENGTH_W-1:0] length_reg;
    logic [LENGTH_W-1:0] clamped_len;
    logic [MAX_PATTERN:0] start_row_reg;
    logic [MAX_PATTERN:0] start_row_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                words_reg[i] <= '0;
            end
            length_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_PATTERN_LOW:    words_reg[0] <= cfg_wr_data;
                REG_PATTERN_SECOND: words_reg[1] <= cfg_wr_data;
                REG_PATTERN_THIRD:  words_reg[2] <= cfg_wr_data;
                REG_PATTERN_HIGH:   words_reg[3] <= cfg_wr_data;
                REG_PATTERN_LENGTH: length_reg   <= cfg_wr_data[LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    assign clamped_len = (length_reg > LENGTH_W'(MAX_PATTERN)) ?
                         LENGTH_W'(MAX_PATTERN) : length_reg;
    assign used_len = clamped_len[LEN_W-1:0];

    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            pattern_bytes[k*8 +: 8] = words_reg[2'(k >> 3)][(k & 7) * 8 +: 8];
            star_mask[k] = (pattern_bytes[k*8 +: 8] == STAR_CODE);
            use_mask[k]  = (LENGTH_W'(k + 1) <= clamped_len);
        end
    end

    // empty-text closure, a leading star never matches
    always_comb begin
        start_row_next    = '0;
        start_row_next[0] = 1'b1;
        for (int j = 2; j <= MAX_PATTERN; j++) begin
            if (use_mask[j-1] && star_mask[j-1]) begin
                start_row_next[j] = start_row_next[j-2];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_row_reg <= (MAX_PATTERN + 1)'(1);
        end else begin
            start_row_reg <= start_row_next;
        end
    end

    assign start_row = start_row_reg;

endmodule

/* sv/rdsm_front.sv */
`timescale 1ns / 1ps
module rdsm_front #(
    parameter int MAX_PATTERN = rdsm_pkg::MAX_PATTERN_DEF
) (
    input  logic [7:0]                 text_byte,
    input  logic                       end_of_text,
    input  logic                       empty_text,
    input  logic [MAX_PATTERN*8-1:0]   pattern_bytes,
    output logic [MAX_PATTERN-1:0]     hit,
    output rdsm_pkg::rdsm_kind_t       kind
);
    import rdsm_pkg::*;

    // per-position element compare, done before the row pass
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            hit[k] = (pattern_bytes[k*8 +: 8] == DOT_CODE) ||
                     (pattern_bytes[k*8 +: 8] == text_byte);
        end
    end

    always_comb begin
        if (empty_text) begin
            kind = KIND_EMPTY;
        end else if (end_of_text) begin
            kind = KIND_LAST;
        end else begin
            kind = KIND_BYTE;
        end
    end

endmodule

/* sv/rdsm_queue.sv */
`timescale 1ns / 1ps
module rdsm_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = rdsm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output logic [DATA_W-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* sv/rdsm_back.sv */
`timescale 1ns / 1ps
module rdsm_back #(
    parameter int MAX_PATTERN = rdsm_pkg::MAX_PATTERN_DEF,
    parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   item_valid,
    input  logic [MAX_PATTERN-1:0] item_hit,
    input  rdsm_pkg::rdsm_kind_t   item_kind,
    output logic                   item_pop,
    input  logic [MAX_PATTERN-1:0] star_mask,
    input  logic [MAX_PATTERN-1:0] use_mask,
    input  logic [LEN_W-1:0]       used_len,
    input  logic [MAX_PATTERN:0]   start_row,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_matched,
    output logic                   out_final
);
    import rdsm_pkg::*;

    logic [MAX_PATTERN:0] match_row_reg;
    logic                 at_start_reg;
    logic                 valid_reg;
    logic                 matched_reg;
    logic                 final_reg;
    logic [MAX_PATTERN:0] base_row;
    logic [MAX_PATTERN:0] row_next;
    logic                 closes;

    assign item_pop = item_valid && (!valid_reg || out_ready);
    assign base_row = at_start_reg ? start_row : match_row_reg;
    assign closes   = (item_kind == KIND_LAST) || (item_kind == KIND_EMPTY);

    // one left-to-right pass, a star looks at the bit two places back
    always_comb begin
        row_next    = '0;
        row_next[1] = use_mask[0] && !star_mask[0] && base_row[0] && item_hit[0];
        for (int j = 2; j <= MAX_PATTERN; j++) begin
            if (use_mask[j-1]) begin
                if (!star_mask[j-1]) begin
                    row_next[j] = base_row[j-1] && item_hit[j-1];
                end else begin
                    row_next[j] = row_next[j-2] || (base_row[j] && item_hit[j-2]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_row_reg <= '0;
            at_start_reg  <= 1'b1;
            valid_reg     <= 1'b0;
        end else begin
            if (item_pop) begin
                valid_reg <= 1'b1;
                if (closes) begin
                    match_row_reg <= '0;
                    at_start_reg  <= 1'b1;
                end else begin
                    match_row_reg <= row_next;
                    at_start_reg  <= 1'b0;
                end
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_pop) begin
            matched_reg <= (item_kind == KIND_EMPTY) ? start_row[used_len] : row_next[used_len];
            final_reg   <= closes;
        end
    end

    assign out_valid   = valid_reg;
    assign out_matched = matched_reg;
    assign out_final   = final_reg;

    a_close_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        item_pop && closes |=> at_start_reg && (match_row_reg == '0))
        else $error("text close did not restore the starting row");

    a_start_row_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        at_start_reg |-> (match_row_reg == '0))
        else $error("stale row kept at text start");

    a_pop_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        item_pop |=> valid_reg)
        else $error("popped request produced no result");

    a_final_on_close: assert property (@(posedge aclk) disable iff (!aresetn)
        item_pop |=> (final_reg == $past(closes)))
        else $error("final verdict flag mismatch");

endmodule

/* sv/regex_dot_star_matcher.sv */
`timescale 1ns / 1ps
// a request accepted on s_ is written to the request queue, and the back stage then registers its result on m_
// throughput: one text byte per cycle while m_tready is high, set by the single-pass row update in the back stage
// the two-entry request queue takes at least one more request while a result waits on m_tready
// reset: synchronous active-low aresetn clears pattern, length, queue and output valid,
// and puts the row at the start of a new text (empty pattern, starting row = bit 0 set)
module regex_dot_star_matcher #(
    parameter int MAX_PATTERN = rdsm_pkg::MAX_PATTERN_DEF,
    parameter int QUEUE_DEPTH = rdsm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port, register index as listed in the register map
    input  logic                           cfg_wr_en,
    input  logic [rdsm_pkg::REG_IDX_W-1:0] cfg_wr_index,
    input  logic [rdsm_pkg::WORD_W-1:0]    cfg_wr_data,
    // text requests
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [7:0] text_byte
    input  logic                           s_tlast,  // end_of_text
    input  logic                           s_tuser,  // empty_text
    // match results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,  // [0] matched, [7:1] zero
    output logic                           m_tlast   // final_verdict
);
    import rdsm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int Q_W   = MAX_PATTERN + 2;

    // pattern bytes for the front compare, masks, length and start row for the back row pass
    logic [MAX_PATTERN*8-1:0] pattern_bytes;
    logic [MAX_PATTERN-1:0]   star_mask;
    logic [MAX_PATTERN-1:0]   use_mask;
    logic [LEN_W-1:0]         used_len;
    logic [MAX_PATTERN:0]     start_row;

    // front side: element hits and request kind
    logic [MAX_PATTERN-1:0]   front_hit;
    rdsm_kind_t               front_kind;

    // queue
    logic                     q_full;
    logic                     q_not_empty;
    logic                     q_pop;
    logic [Q_W-1:0]           q_push_data;
    logic [Q_W-1:0]           q_pop_data;

    logic                     out_matched;

    rdsm_cfg #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .pattern_bytes (pattern_bytes),
        .star_mask     (star_mask),
        .use_mask      (use_mask),
        .used_len      (used_len),
        .start_row     (start_row)
    );

    rdsm_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .text_byte     (s_tdata),
        .end_of_text   (s_tlast),
        .empty_text    (s_tuser),
        .pattern_bytes (pattern_bytes),
        .hit           (front_hit),
        .kind          (front_kind)
    );

    // queue entry: hits above, kind in the low two bits
    assign q_push_data = {front_hit, front_kind};
    assign s_tready    = !q_full;

    rdsm_queue #(
        .DATA_W (Q_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_pop_data)
    );

    rdsm_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (q_not_empty),
        .item_hit    (q_pop_data[Q_W-1:2]),
        .item_kind   (rdsm_kind_t'(q_pop_data[1:0])),
        .item_pop    (q_pop),
        .star_mask   (star_mask),
        .use_mask    (use_mask),
        .used_len    (used_len),
        .start_row   (start_row),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_matched (out_matched),
        .out_final   (m_tlast)
    );

    assign m_tdata = {7'b0, out_matched};

endmodule
